FILE: rtl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// types and register codes shared by the pid step controller files
// ----------------------------------------------------------------------------
package pdc_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_P_GAIN         = 3'd0,
		REG_I_GAIN         = 3'd1,
		REG_D_GAIN         = 3'd2,
		REG_DEAD_BAND      = 3'd3,
		REG_OUTPUT_LIMIT   = 3'd4,
		REG_INTEGRAL_LIMIT = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic signed [15:0] p_gain;
		logic signed [15:0] i_gain;
		logic signed [15:0] d_gain;
		logic        [14:0] dead_band;
		logic        [14:0] output_limit;
		logic        [14:0] integral_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] measured_value;
		logic signed [15:0] target_value;
		logic               clear_request;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] drive_value;
		logic               output_saturated;
	} out_item_t;

endpackage

FILE: rtl/pdc_stream_if.sv
// ----------------------------------------------------------------------------
// pdc_stream_if
// valid/ready channel carrying one payload word per transfer
// ----------------------------------------------------------------------------
interface pdc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/pdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pdc_cfg_regs
// gain, dead band and limit registers behind the write port
// ----------------------------------------------------------------------------
module pdc_cfg_regs
	import pdc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gain         <= '0;
			cfg_q.i_gain         <= '0;
			cfg_q.d_gain         <= '0;
			cfg_q.dead_band      <= '0;
			cfg_q.output_limit   <= 15'h7fff;
			cfg_q.integral_limit <= 15'h7fff;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_P_GAIN:         cfg_q.p_gain         <= cfg_wdata;
				REG_I_GAIN:         cfg_q.i_gain         <= cfg_wdata;
				REG_D_GAIN:         cfg_q.d_gain         <= cfg_wdata;
				REG_DEAD_BAND:      cfg_q.dead_band      <= cfg_wdata[14:0];
				REG_OUTPUT_LIMIT:   cfg_q.output_limit   <= cfg_wdata[14:0];
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/pdc_core.sv
// ----------------------------------------------------------------------------
// pdc_core
// one pid step: dead band, three gain products, integral clamp, output clamp
// ----------------------------------------------------------------------------
module pdc_core
	import pdc_pkg::*;
#(
	parameter int unsigned FRACTION_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      advance,
	input  in_item_t  item,
	output out_item_t res
);

	localparam int unsigned EW = 17;
	localparam int unsigned DW = 18;
	localparam int unsigned PW = 33;
	localparam int unsigned IW = 34;
	localparam int unsigned SW = 36;
	localparam logic signed [SW-1:0] BIAS = SW'((64'd1 << FRACTION_BITS) - 64'd1);

	logic signed [EW-1:0] prev_err_q;
	logic signed [31:0]   integ_q;

	logic signed [EW-1:0] err_raw;
	logic signed [EW-1:0] dband;
	logic signed [EW-1:0] err;
	logic signed [DW-1:0] diff;
	logic signed [PW-1:0] pterm;
	logic signed [PW-1:0] iprod;
	logic signed [IW-1:0] dterm;
	logic signed [IW-1:0] integ_raw;
	logic signed [IW-1:0] ilim;
	logic signed [IW-1:0] integ;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] whole;
	logic signed [SW-1:0] olim;
	logic signed [SW-1:0] drive;
	logic                 sat;

	always_comb begin
		err_raw = EW'(item.target_value) - EW'(item.measured_value);
		dband   = EW'(cfg.dead_band);
		if (err_raw < dband && err_raw > -dband)
			err = '0;
		else
			err = err_raw;

		diff  = DW'(err) - DW'(prev_err_q);
		pterm = PW'(cfg.p_gain) * PW'(err);
		iprod = PW'(cfg.i_gain) * PW'(err);
		dterm = IW'(cfg.d_gain) * IW'(diff);

		integ_raw = IW'(integ_q) + IW'(iprod);
		ilim      = IW'(cfg.integral_limit) <<< FRACTION_BITS;
		if (integ_raw > ilim)
			integ = ilim;
		else if (integ_raw < -ilim)
			integ = -ilim;
		else
			integ = integ_raw;

		sum   = SW'(pterm) + SW'(integ) + SW'(dterm);
		whole = (sum + (sum[SW-1] ? BIAS : SW'(0))) >>> FRACTION_BITS;
		olim  = SW'(cfg.output_limit);
		sat   = 1'b0;
		if (whole > olim) begin
			drive = olim;
			sat   = 1'b1;
		end else if (whole < -olim) begin
			drive = -olim;
			sat   = 1'b1;
		end else begin
			drive = whole;
		end

		if (item.clear_request) begin
			res.drive_value      = '0;
			res.output_saturated = 1'b0;
		end else begin
			res.drive_value      = drive[15:0];
			res.output_saturated = sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integ_q    <= '0;
		end else if (advance) begin
			if (item.clear_request) begin
				prev_err_q <= '0;
				integ_q    <= '0;
			end else begin
				prev_err_q <= err;
				integ_q    <= integ[31:0];
			end
		end
	end

	a_clear_zeroes_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.clear_request |=> prev_err_q == '0 && integ_q == '0)
		else $error("state not cleared after clear request");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res.output_saturated |->
			(SW'(res.drive_value) == olim || SW'(res.drive_value) == -olim))
		else $error("saturated drive not at limit");

endmodule

FILE: rtl/pid_deadband_clamped.sv
// ----------------------------------------------------------------------------
// pid_deadband_clamped
// positional pid step with dead band, integral clamp and output clamp
//
//   channel  dir  handshake            payload
//   item     in   item.valid/ready     measured_value, target_value, clear_request
//   result   out  result.valid/ready   drive_value, output_saturated
//   cfg      in   cfg_we               cfg_index, cfg_wdata
//
// one item per cycle while the result is not stalled; a result passes the input
// register, then the result register; the integral and error history close
// their loop through the combinational compute logic
// arst_n clears the handshake state and the history and resets the configuration
// a stalled result holds the result register; the input register still takes
// an item and stalls only when both registers are full
// ----------------------------------------------------------------------------
module pid_deadband_clamped
	import pdc_pkg::*;
#(
	parameter int unsigned FRACTION_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	pdc_stream_if.sink             item,
	pdc_stream_if.source           result
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_c;
	out_item_t res_q;
	logic      res_valid_q;
	logic      advance;
	logic      in_ready;

	pdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pdc_core #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.item    (item_s1),
		.res     (res_c)
	);

	assign advance  = valid_s1 && (!res_valid_q || result.ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && item.valid)
			item_s1 <= item.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_c;
	end

	assign item.ready   = in_ready;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && res_valid_q && !result.ready)
		else $error("input stalled with room in the pipeline");

	a_result_from_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(advance))
		else $error("result valid without an advance");

	a_held_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready && !advance |=> res_valid_q && $stable(res_q))
		else $error("stalled result lost");

endmodule
